>>> src/aspc_pkg.sv
`default_nettype none
package aspc_pkg;

  // Field widths
  localparam int unsigned FILL_W = 25;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CRC_W  = 32;

  // Limits and CRC constants
  localparam logic [FILL_W-1:0] FILL_MAX     = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX      = '1;
  localparam logic [CRC_W-1:0]  CRC_POLY     = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0]  CRC_ONES     = '1;
  localparam logic [FILL_W-1:0] TARGET_RESET = 25'd1048576;

  // Defaults of the top-level parameters
  localparam int unsigned ALIGN_BYTES_DEF     = 16;
  localparam int unsigned MAX_BLOCK_BYTES_DEF = 32'd16777215;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Request codes
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_EMPTY = 2'd1;
  localparam logic [1:0] REQ_SEAL  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_SLICE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // All results caused by one accepted item
  typedef struct packed {
    logic              has_byte;
    logic              has_slice;
    logic              has_flush;
    logic [7:0]        byte_value;
    logic [FILL_W-1:0] buffer_position;
    logic              byte_ovf;
    logic [CNT_W-1:0]  slice_index;
    logic [FILL_W-1:0] slice_offset;
    logic [LEN_W-1:0]  slice_length;
    logic [CRC_W-1:0]  slice_crc;
    logic              slice_ovf;
    logic [FILL_W-1:0] object_bytes;
    logic [CNT_W-1:0]  object_first_slice;
    logic [CNT_W-1:0]  object_slice_count;
    logic              object_ovf;
  } bundle_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [1:0]        result_kind;
    logic [7:0]        byte_value;
    logic [FILL_W-1:0] buffer_position;
    logic [CNT_W-1:0]  slice_index;
    logic [FILL_W-1:0] slice_offset;
    logic [LEN_W-1:0]  slice_length;
    logic [CRC_W-1:0]  slice_crc;
    logic [FILL_W-1:0] object_bytes;
    logic [CNT_W-1:0]  object_first_slice;
    logic [CNT_W-1:0]  object_slice_count;
    logic              overflow;
    logic              is_last_result;
  } result_t;

  // Reflected CRC32C update by one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/aspc_if.sv
`default_nettype none
// Input item channel
interface aspc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       is_first;
  logic       is_last;
  modport source(output valid, req_type, data_byte, is_first, is_last, input ready);
  modport sink(input valid, req_type, data_byte, is_first, is_last, output ready);
endinterface

// Result channel
interface aspc_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [7:0]                   byte_value;
  logic [aspc_pkg::FILL_W-1:0]  buffer_position;
  logic [aspc_pkg::CNT_W-1:0]   slice_index;
  logic [aspc_pkg::FILL_W-1:0]  slice_offset;
  logic [aspc_pkg::LEN_W-1:0]   slice_length;
  logic [aspc_pkg::CRC_W-1:0]   slice_crc;
  logic [aspc_pkg::FILL_W-1:0]  object_bytes;
  logic [aspc_pkg::CNT_W-1:0]   object_first_slice;
  logic [aspc_pkg::CNT_W-1:0]   object_slice_count;
  logic                         overflow;
  logic                         is_last_result;
  modport source(output valid, result_kind, byte_value, buffer_position, slice_index,
                 slice_offset, slice_length, slice_crc, object_bytes,
                 object_first_slice, object_slice_count, overflow, is_last_result,
                 input ready);
  modport sink(input valid, result_kind, byte_value, buffer_position, slice_index,
               slice_offset, slice_length, slice_crc, object_bytes,
               object_first_slice, object_slice_count, overflow, is_last_result,
               output ready);
endinterface

// Configuration write channel
interface aspc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [aspc_pkg::FILL_W-1:0] target_object_bytes;
  modport source(output valid, target_object_bytes, input ready);
  modport sink(input valid, target_object_bytes, output ready);
endinterface
`default_nettype wire

>>> src/aspc_front.sv
`default_nettype none
module aspc_front #(
  parameter int unsigned ALIGN_BYTES     = aspc_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = aspc_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  aspc_in_if.sink        in_i,
  aspc_cfg_if.sink       cfg_i,
  input  wire logic      full_i,
  output aspc_pkg::bundle_t push_data_o,
  output logic           push_o
);

  localparam int unsigned MOD_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam int unsigned PAD_W = $clog2(ALIGN_BYTES + 1);
  localparam int unsigned FW    = aspc_pkg::FILL_W;
  localparam logic [MOD_W-1:0] MOD_TOP = MOD_W'(ALIGN_BYTES - 1);
  localparam logic [MOD_W-1:0] SAT_MOD = MOD_W'(33554431 % ALIGN_BYTES);
  localparam logic [aspc_pkg::LEN_W-1:0] LEN_CAP =
    (MAX_BLOCK_BYTES < 32'hFF_FFFF) ? aspc_pkg::LEN_W'(MAX_BLOCK_BYTES) : aspc_pkg::LEN_MAX;

  logic [FW-1:0]                  fill_q, fill_d, start_q, start_d, target_q;
  logic [MOD_W-1:0]               mod_q, mod_d;
  logic [aspc_pkg::CNT_W-1:0]     cnt_q, cnt_d, ofs_q, ofs_d;
  logic [aspc_pkg::CRC_W-1:0]     crc_q, crc_d;
  logic [aspc_pkg::LEN_W-1:0]     len_q, len_d;
  logic                           ssat_q, ssat_d, osat_q, osat_d;

  logic [PAD_W-1:0] pad;
  logic [FW:0]      al_sum;
  logic             open_sat;
  logic [FW-1:0]    al_fill;
  logic [MOD_W-1:0] al_mod;
  logic             accept, slice_now, flush_now, bsat;
  aspc_pkg::bundle_t bnd;

  function automatic logic [MOD_W-1:0] mod_inc(input logic [MOD_W-1:0] m);
    return (m == MOD_TOP) ? '0 : m + 1'b1;
  endfunction

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && !full_i;

  // Round the fill up to the next aligned offset, saturating at the top
  assign pad      = (mod_q == '0) ? '0 : PAD_W'(ALIGN_BYTES) - PAD_W'(mod_q);
  assign al_sum   = {1'b0, fill_q} + (FW+1)'(pad);
  assign open_sat = al_sum > {1'b0, aspc_pkg::FILL_MAX};
  assign al_fill  = open_sat ? aspc_pkg::FILL_MAX : al_sum[FW-1:0];
  assign al_mod   = open_sat ? SAT_MOD : '0;

  // Classify the item and build all of its results
  always_comb begin
    fill_d = fill_q; mod_d = mod_q; start_d = start_q; len_d = len_q; crc_d = crc_q;
    ssat_d = ssat_q; osat_d = osat_q; cnt_d = cnt_q; ofs_d = ofs_q;
    bnd = '0; slice_now = 1'b0; flush_now = 1'b0; bsat = 1'b0;
    case (in_i.req_type)
      aspc_pkg::REQ_DATA: begin
        if (in_i.is_first || len_q == '0) begin
          fill_d = al_fill; mod_d = al_mod; start_d = al_fill; len_d = '0;
          crc_d = aspc_pkg::CRC_ONES; ssat_d = open_sat; osat_d = osat_q | open_sat;
          bsat = open_sat;
        end
        bnd.has_byte        = 1'b1;
        bnd.byte_value      = in_i.data_byte;
        bnd.buffer_position = fill_d;
        if (fill_d == aspc_pkg::FILL_MAX) begin
          bsat = 1'b1;
        end else begin
          fill_d = fill_d + 1'b1;
          mod_d  = mod_inc(mod_d);
        end
        if (len_d >= LEN_CAP) begin
          bsat = 1'b1;
        end else begin
          len_d = len_d + 1'b1;
        end
        crc_d = aspc_pkg::crc_byte(crc_d, in_i.data_byte);
        if (bsat) begin
          ssat_d = 1'b1;
          osat_d = 1'b1;
        end
        bnd.byte_ovf = bsat;
        slice_now    = in_i.is_last;
      end
      aspc_pkg::REQ_EMPTY: begin
        fill_d = al_fill; mod_d = al_mod; start_d = al_fill; len_d = '0;
        crc_d = aspc_pkg::CRC_ONES; ssat_d = open_sat; osat_d = osat_q | open_sat;
        slice_now = 1'b1;
      end
      aspc_pkg::REQ_SEAL: begin
        len_d = '0; crc_d = aspc_pkg::CRC_ONES; ssat_d = 1'b0;
        flush_now = (fill_q != '0);
      end
      default: begin
      end
    endcase
    // Close the slice
    if (slice_now) begin
      bnd.has_slice    = 1'b1;
      bnd.slice_index  = cnt_d;
      bnd.slice_offset = start_d;
      bnd.slice_length = len_d;
      bnd.slice_crc    = ~crc_d;
      bnd.slice_ovf    = ssat_d;
      cnt_d  = cnt_d + 1'b1;
      len_d  = '0;
      crc_d  = aspc_pkg::CRC_ONES;
      ssat_d = 1'b0;
      flush_now = (fill_d >= target_q);
    end
    // Flush the object
    if (flush_now) begin
      bnd.has_flush          = 1'b1;
      bnd.object_bytes       = fill_d;
      bnd.object_first_slice = ofs_d;
      bnd.object_slice_count = cnt_d - ofs_d;
      bnd.object_ovf         = osat_d;
      ofs_d  = cnt_d;
      fill_d = '0;
      mod_d  = '0;
      osat_d = 1'b0;
    end
  end

  assign push_data_o = bnd;
  assign push_o      = accept && (bnd.has_byte || bnd.has_slice || bnd.has_flush);

  // Hold packing state; advance on each accepted transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      mod_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      crc_q    <= aspc_pkg::CRC_ONES;
      ssat_q   <= 1'b0;
      osat_q   <= 1'b0;
      cnt_q    <= '0;
      ofs_q    <= '0;
      target_q <= aspc_pkg::TARGET_RESET;
    end else begin
      if (cfg_i.valid) begin
        target_q <= cfg_i.target_object_bytes;
      end
      if (accept) begin
        fill_q  <= fill_d;
        mod_q   <= mod_d;
        start_q <= start_d;
        len_q   <= len_d;
        crc_q   <= crc_d;
        ssat_q  <= ssat_d;
        osat_q  <= osat_d;
        cnt_q   <= cnt_d;
        ofs_q   <= ofs_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/aspc_fifo.sv
`default_nettype none
module aspc_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire aspc_pkg::bundle_t  push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output aspc_pkg::bundle_t       head_o,
  output logic                    empty_o
);

  localparam int unsigned DEPTH = aspc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  aspc_pkg::bundle_t  mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [PTR_W:0]     count_q;

  assign full_o  = (count_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/aspc_back.sv
`default_nettype none
module aspc_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aspc_pkg::bundle_t head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  aspc_out_if.source             out_o
);

  logic [2:0]        done_q, done_d, rem, sel, rem_after;
  logic              valid_q, load;
  aspc_pkg::result_t res_q, res_d;

  // Pick the next pending result of the head entry
  assign rem       = {head_i.has_flush, head_i.has_slice, head_i.has_byte} & ~done_q;
  assign sel       = rem & (~rem + 1'b1);
  assign rem_after = rem & ~sel;
  assign load      = !empty_i && (!valid_q || out_o.ready);
  assign pop_o     = load && (rem_after == '0);

  always_comb begin
    done_d = done_q;
    if (pop_o) begin
      done_d = '0;
    end else if (load) begin
      done_d = done_q | sel;
    end
  end

  // Format the selected result
  always_comb begin
    res_d = '0;
    res_d.is_last_result = (rem_after == '0);
    if (sel[0]) begin
      res_d.result_kind     = aspc_pkg::KIND_BYTE;
      res_d.byte_value      = head_i.byte_value;
      res_d.buffer_position = head_i.buffer_position;
      res_d.overflow        = head_i.byte_ovf;
    end else if (sel[1]) begin
      res_d.result_kind  = aspc_pkg::KIND_SLICE;
      res_d.slice_index  = head_i.slice_index;
      res_d.slice_offset = head_i.slice_offset;
      res_d.slice_length = head_i.slice_length;
      res_d.slice_crc    = head_i.slice_crc;
      res_d.overflow     = head_i.slice_ovf;
    end else begin
      res_d.result_kind        = aspc_pkg::KIND_FLUSH;
      res_d.object_bytes       = head_i.object_bytes;
      res_d.object_first_slice = head_i.object_first_slice;
      res_d.object_slice_count = head_i.object_slice_count;
      res_d.overflow           = head_i.object_ovf;
    end
  end

  // Hold the output register until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else begin
      done_q <= done_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.result_kind        = res_q.result_kind;
  assign out_o.byte_value         = res_q.byte_value;
  assign out_o.buffer_position    = res_q.buffer_position;
  assign out_o.slice_index        = res_q.slice_index;
  assign out_o.slice_offset       = res_q.slice_offset;
  assign out_o.slice_length       = res_q.slice_length;
  assign out_o.slice_crc          = res_q.slice_crc;
  assign out_o.object_bytes       = res_q.object_bytes;
  assign out_o.object_first_slice = res_q.object_first_slice;
  assign out_o.object_slice_count = res_q.object_slice_count;
  assign out_o.overflow           = res_q.overflow;
  assign out_o.is_last_result     = res_q.is_last_result;

endmodule
`default_nettype wire

>>> src/aligned_slice_packer_crc32c.sv
`default_nettype none
// Aligned slice packer with CRC32C. Takes one data byte, empty-block or seal request
// per cycle on in_i while the queue is not full, and returns byte writes, slice records
// and object flush records on out_o, one result per cycle while out_o is ready, the last
// result of each item marked by is_last_result. The front stage updates the fill, slice
// and CRC state for an item in the cycle it is accepted and queues all of its results
// (four-entry queue); the back stage hands them out from an output register. Each result
// of an item is its own transfer on out_o: a plain byte stream runs at one item per cycle
// while out_o is ready, and the output port sets the rate when slices and flushes pile
// up. Padding bytes from aligning each block to ALIGN_BYTES are counted in the fill but
// never written. target_object_bytes is written on cfg_i; write it only while the block
// is idle.
module aligned_slice_packer_crc32c #(
  parameter int unsigned ALIGN_BYTES     = aspc_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned MAX_BLOCK_BYTES = aspc_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  aspc_in_if.sink    in_i,
  aspc_cfg_if.sink   cfg_i,
  aspc_out_if.source out_o
);

  aspc_pkg::bundle_t push_data, head;
  logic              push, full, pop, empty;

  // Accept and classify items
  aspc_front #(
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .full_i      (full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  // Decouple front from back
  aspc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Emit results one per transfer
  aspc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
